### sv/ffc_pkg.sv
// ============================================================================
// ffc_pkg
// Shared widths, ranges, codes and types of the fuzzy freshness classifier.
// ============================================================================
package ffc_pkg;

    // payload widths
    localparam int GAS_A_W    = 10;
    localparam int GAS_B_W    = 14;
    localparam int PH_W       = 11;
    localparam int CLASS_W    = 2;
    localparam int STRENGTH_W = 13;

    // default grade resolution, Q1.12
    localparam int GRADE_BITS_DEF = 12;

    // saturation limits of the readings
    localparam logic [GAS_A_W-1:0] GAS_A_MAX = GAS_A_W'(1000);
    localparam logic [GAS_B_W-1:0] GAS_B_MAX = GAS_B_W'(10000);
    localparam logic [PH_W-1:0]    PH_MAX    = PH_W'(1400);

    // freshness class codes
    localparam logic [CLASS_W-1:0] CLS_VERY_FRESH = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_FRESH      = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_LESS_FRESH = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_SPOILED    = 2'd3;

    // membership region codes
    localparam logic [1:0] RG_ZERO = 2'd0;
    localparam logic [1:0] RG_FULL = 2'd1;
    localparam logic [1:0] RG_RISE = 2'd2;
    localparam logic [1:0] RG_FALL = 2'd3;

    // stage load enables handed to the membership units
    typedef struct packed {
        logic s1;
        logic s2;
    } t_pipe_en;

endpackage

### sv/ffc_in_if.sv
// ============================================================================
// ffc_in_if
// Sample channel: two gas readings and one pH reading with valid/ready.
// ============================================================================
interface ffc_in_if;
    import ffc_pkg::*;

    logic               valid;
    logic               ready;
    logic [GAS_A_W-1:0] gas_a_ppm;
    logic [GAS_B_W-1:0] gas_b_ppm;
    logic [PH_W-1:0]    ph_centi;

    modport source (output valid, output gas_a_ppm, output gas_b_ppm, output ph_centi,
                    input ready);
    modport sink   (input valid, input gas_a_ppm, input gas_b_ppm, input ph_centi,
                    output ready);
endinterface

### sv/ffc_out_if.sv
// ============================================================================
// ffc_out_if
// Result channel: freshness class and winning strength with valid/ready.
// ============================================================================
interface ffc_out_if;
    import ffc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CLASS_W-1:0]    freshness_class;
    logic [STRENGTH_W-1:0] class_strength;

    modport source (output valid, output freshness_class, output class_strength,
                    input ready);
    modport sink   (input valid, input freshness_class, input class_strength,
                    output ready);
endinterface

### sv/fuzzy_freshness_classifier.sv
// ============================================================================
// fuzzy_freshness_classifier
// Max-min fuzzy inference over two gas readings and a pH reading.
// ============================================================================
// Usage
//   i_sample carries one set of readings (gas_a_ppm, gas_b_ppm, ph_centi);
//   a transfer happens when valid and ready are both high. o_result carries
//   the freshness class and its winning strength in Q1.GRADE_BITS, masked to
//   13 bits, one result per sample, in order.
//   Readings above their ranges are clamped before grading.
// Timing
//   four register stages: membership region, reciprocal multiply, rule
//   evaluation, argmax. A result is valid once its sample reaches the argmax
//   register, and it transfers on an edge where o_result.ready is high.
//   One sample per cycle is accepted while results are taken every cycle.
// Reset and stall
//   synchronous active-low reset empties every stage; payload is not cleared.
//   Each stage loads when it is empty or the stage after it moves, so a
//   stalled receiver fills the bubbles first, then holds i_sample.ready low;
//   nothing is dropped or repeated.
// ============================================================================
module fuzzy_freshness_classifier #(
    parameter int GRADE_BITS = ffc_pkg::GRADE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffc_in_if.sink     i_sample,
    ffc_out_if.source  o_result
);
    import ffc_pkg::*;

    localparam int GW = GRADE_BITS + 1;

    typedef logic [GW-1:0] t_grade;

    function automatic t_grade f_max(input t_grade a, input t_grade b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_grade f_min(input t_grade a, input t_grade b);
        return (a < b) ? a : b;
    endfunction

    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;
    t_pipe_en memb_en;

    logic [GAS_A_W-1:0] sat_a;
    logic [GAS_B_W-1:0] sat_b;
    logic [PH_W-1:0]    sat_ph;

    t_grade a_lo, a_md, a_hi, b_lo, b_md, b_hi, ph_ac, ph_nt, ph_bs;
    t_grade g_lo, g_md, g_hi;
    t_grade n_s0, n_s1, n_s2, n_s3;
    t_grade r_s0, r_s1, r_s2, r_s3;

    logic [CLASS_W-1:0] n_cls, r_cls;
    t_grade             n_best;
    t_grade             r_str;

    // stage enables: a stage loads when empty or when its successor loads
    assign en4 = !r_v4 || o_result.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_sample.ready = en1;
    assign memb_en.s1 = en1;
    assign memb_en.s2 = en2;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_sample.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // clamp readings to their ranges
    assign sat_a  = (i_sample.gas_a_ppm > GAS_A_MAX) ? GAS_A_MAX : i_sample.gas_a_ppm;
    assign sat_b  = (i_sample.gas_b_ppm > GAS_B_MAX) ? GAS_B_MAX : i_sample.gas_b_ppm;
    assign sat_ph = (i_sample.ph_centi  > PH_MAX)    ? PH_MAX    : i_sample.ph_centi;

    // membership units, stages 1 and 2
    ffc_memb #(.GRADE_BITS(GRADE_BITS), .XW(GAS_A_W), .A(0), .B(50), .C(200))
        u_a_lo (.i_clk(i_clk), .i_en(memb_en), .i_x(sat_a), .o_grade(a_lo));
    ffc_memb #(.GRADE_BITS(GRADE_BITS), .XW(GAS_A_W), .A(100), .B(300), .C(600))
        u_a_md (.i_clk(i_clk), .i_en(memb_en), .i_x(sat_a), .o_grade(a_md));
    ffc_memb #(.GRADE_BITS(GRADE_BITS), .XW(GAS_A_W), .A(500), .B(800), .C(1000))
        u_a_hi (.i_clk(i_clk), .i_en(memb_en), .i_x(sat_a), .o_grade(a_hi));
    ffc_memb #(.GRADE_BITS(GRADE_BITS), .XW(GAS_B_W), .A(200), .B(500), .C(1500))
        u_b_lo (.i_clk(i_clk), .i_en(memb_en), .i_x(sat_b), .o_grade(b_lo));
    ffc_memb #(.GRADE_BITS(GRADE_BITS), .XW(GAS_B_W), .A(800), .B(2500), .C(5000))
        u_b_md (.i_clk(i_clk), .i_en(memb_en), .i_x(sat_b), .o_grade(b_md));
    ffc_memb #(.GRADE_BITS(GRADE_BITS), .XW(GAS_B_W), .A(3500), .B(7000), .C(10000))
        u_b_hi (.i_clk(i_clk), .i_en(memb_en), .i_x(sat_b), .o_grade(b_hi));
    ffc_memb #(.GRADE_BITS(GRADE_BITS), .XW(PH_W), .A(0), .B(600), .C(700))
        u_ph_ac (.i_clk(i_clk), .i_en(memb_en), .i_x(sat_ph), .o_grade(ph_ac));
    ffc_memb #(.GRADE_BITS(GRADE_BITS), .XW(PH_W), .A(600), .B(700), .C(800))
        u_ph_nt (.i_clk(i_clk), .i_en(memb_en), .i_x(sat_ph), .o_grade(ph_nt));
    // basic peaks at the top of the clamped range, so full at pH 14
    ffc_memb #(.GRADE_BITS(GRADE_BITS), .XW(PH_W), .A(700), .B(1400), .C(1400))
        u_ph_bs (.i_clk(i_clk), .i_en(memb_en), .i_x(sat_ph), .o_grade(ph_bs));

    // stage 3: merge gas levels and evaluate the rules
    always_comb begin
        g_lo = f_max(a_lo, b_lo);
        g_md = f_max(a_md, b_md);
        g_hi = f_max(a_hi, b_hi);
        n_s0 = f_min(g_lo, ph_nt);
        n_s1 = f_max(f_min(g_lo, ph_ac), f_min(g_md, ph_nt));
        n_s2 = f_max(f_min(g_lo, ph_bs), f_min(g_md, ph_ac));
        n_s3 = f_max(f_max(f_min(g_md, ph_bs), g_hi), f_max(ph_bs, f_min(g_hi, ph_nt)));
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    // stage 4: argmax, lower class wins a tie
    always_comb begin
        n_cls  = CLS_VERY_FRESH;
        n_best = r_s0;
        if (r_s1 > n_best) begin
            n_cls  = CLS_FRESH;
            n_best = r_s1;
        end
        if (r_s2 > n_best) begin
            n_cls  = CLS_LESS_FRESH;
            n_best = r_s2;
        end
        if (r_s3 > n_best) begin
            n_cls  = CLS_SPOILED;
            n_best = r_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_cls <= n_cls;
            r_str <= n_best;
        end
    end

    // result transfer
    assign o_result.valid           = r_v4;
    assign o_result.freshness_class = r_cls;
    assign o_result.class_strength  = STRENGTH_W'(r_str);

endmodule

### sv/ffc_memb.sv
// ============================================================================
// ffc_memb
// Two-stage triangular membership unit: region and distance, then a
// constant-reciprocal multiply that gives the exact floored grade.
// ============================================================================
module ffc_memb #(
    parameter int GRADE_BITS = ffc_pkg::GRADE_BITS_DEF,
    parameter int XW         = ffc_pkg::GAS_A_W,
    parameter int A          = 0,
    parameter int B          = 50,
    parameter int C          = 200
) (
    input  logic                  i_clk,
    input  ffc_pkg::t_pipe_en     i_en,
    input  logic [XW-1:0]         i_x,
    output logic [GRADE_BITS:0]   o_grade
);
    import ffc_pkg::*;

    // slopes; a triangle whose peak sits on its right edge has no falling side
    localparam int DR   = B - A;
    localparam int DF   = (C > B) ? (C - B) : DR;
    localparam int DMAX = (DR > DF) ? DR : DF;
    localparam int DW   = $clog2(DMAX);
    localparam int K    = 2 * $clog2(DMAX);
    localparam int PW   = K + GRADE_BITS;

    // reciprocals ceil(2^(K+G)/D), exact for every distance below D
    localparam longint unsigned SCALE = 64'd1 << PW;
    localparam longint unsigned MR    = (SCALE + DR - 1) / DR;
    localparam longint unsigned MF    = (SCALE + DF - 1) / DF;
    localparam longint unsigned MMAX  = (MR > MF) ? MR : MF;
    localparam int              MW    = $clog2(MMAX + 1);

    localparam logic [MW-1:0] MR_V = MW'(MR);
    localparam logic [MW-1:0] MF_V = MW'(MF);
    localparam logic [XW-1:0] A_V  = XW'(A);
    localparam logic [XW-1:0] B_V  = XW'(B);
    localparam logic [XW-1:0] C_V  = XW'(C);

    logic [1:0]    n_rg, r_rg;
    logic [DW-1:0] n_d, r_d;
    logic [MW-1:0] m_sel;
    logic [PW-1:0] prod;
    logic [GRADE_BITS:0] n_grade, r_grade;

    // stage 1: region and distance from the foot on the same side of the peak
    always_comb begin
        n_d = '0;
        priority if (i_x <= A_V) begin
            n_rg = RG_ZERO;
        end else if (i_x == B_V) begin
            n_rg = RG_FULL;
        end else if (i_x >= C_V) begin
            n_rg = RG_ZERO;
        end else if (i_x < B_V) begin
            n_rg = RG_RISE;
            n_d  = DW'(i_x - A_V);
        end else begin
            n_rg = RG_FALL;
            n_d  = DW'(C_V - i_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_rg <= n_rg;
            r_d  <= n_d;
        end
    end

    // stage 2: reciprocal multiply, quotient is the upper part of the product
    assign m_sel = (r_rg == RG_FALL) ? MF_V : MR_V;
    assign prod  = PW'(r_d) * PW'(m_sel);

    always_comb begin
        unique case (r_rg)
            RG_ZERO: n_grade = '0;
            RG_FULL: n_grade = {1'b1, {GRADE_BITS{1'b0}}};
            default: n_grade = {1'b0, prod[PW-1:K]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_grade <= n_grade;
        end
    end

    assign o_grade = r_grade;

endmodule
